/* sv/shell_argument_tokenizer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the shell argument tokenizer
// Same-cycle and next-cycle implication checks, empty under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef SHELL_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH
`define SHELL_ARGUMENT_TOKENIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define SATK_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define SATK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define SATK_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SATK_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/satk_pkg.sv */
// ----------------------------------------------------------------------------
// satk_pkg
// Types, byte constants and helpers shared by the tokenizer modules.
// ----------------------------------------------------------------------------
package satk_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_END_ARG = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_ERROR   = 2'd3
    } satk_kind_t;

    // Parser states; code 7 is unused and reads as between arguments
    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ARG     = 3'd1,
        ST_ARG_ESC = 3'd2,
        ST_SQ      = 3'd3,
        ST_SQ_ESC  = 3'd4,
        ST_DQ      = 3'd5,
        ST_DQ_ESC  = 3'd6
    } satk_state_t;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BSL = 8'h5C;

    // Result queue depth; must be at least 2
    localparam int SATK_FIFO_DEPTH = 4;

    typedef struct packed {
        satk_kind_t  kind;
        logic [7:0]  data;
        logic        last;
    } satk_result_t;

    // Results produced by one byte: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0]   count;
        satk_result_t first;
        satk_result_t second;
    } satk_push_t;

    function automatic logic is_skip_space(input logic [7:0] c);
        return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        return is_skip_space(c) || (c == CH_BS);
    endfunction

    // Translate a double-quote escape letter to its control byte
    function automatic logic [7:0] cook_escape(input logic [7:0] c);
        logic [7:0] r;
        unique case (c)
            8'h61:   r = 8'h07; // a
            8'h62:   r = 8'h08; // b
            8'h74:   r = 8'h09; // t
            8'h6E:   r = 8'h0A; // n
            8'h76:   r = 8'h0B; // v
            8'h66:   r = 8'h0C; // f
            8'h72:   r = 8'h0D; // r
            default: r = c;
        endcase
        return r;
    endfunction

    function automatic satk_result_t mk_result(input satk_kind_t k, input logic [7:0] d);
        satk_result_t r;
        r.kind = k;
        r.data = (k == KIND_BYTE) ? d : 8'h00;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

/* sv/satk_parser.sv */
// ----------------------------------------------------------------------------
// satk_parser
// Parse state register and the per-byte decode into zero to two results.
// ----------------------------------------------------------------------------
module satk_parser
    import satk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  char_byte,
    output satk_push_t  push
);

    satk_state_t state_reg;
    satk_state_t state_next;
    satk_state_t st_eff;
    logic        idle_like;
    logic [1:0]  n;
    satk_result_t r0;
    satk_result_t r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        idle_like = !(state_reg == ST_ARG || state_reg == ST_ARG_ESC ||
                      state_reg == ST_SQ  || state_reg == ST_SQ_ESC  ||
                      state_reg == ST_DQ  || state_reg == ST_DQ_ESC);
        // A non-blank byte between arguments opens an argument
        if (idle_like && (char_byte != CH_NUL) && !is_skip_space(char_byte))
        begin
            st_eff = ST_ARG;
        end
        else if (idle_like)
        begin
            st_eff = ST_IDLE;
        end
        else
        begin
            st_eff = state_reg;
        end
    end

    always_comb
    begin
        n          = 2'd0;
        r0         = mk_result(KIND_BYTE, CH_NUL);
        r1         = mk_result(KIND_BYTE, CH_NUL);
        state_next = st_eff;
        unique case (st_eff)
            ST_ARG:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd2;
                    r0 = mk_result(KIND_END_ARG, CH_NUL);
                    r1 = mk_result(KIND_DONE, CH_NUL);
                    state_next = ST_IDLE;
                end
                else if (char_byte == CH_BSL)
                begin
                    state_next = ST_ARG_ESC;
                end
                else if (char_byte == CH_SQ)
                begin
                    state_next = ST_SQ;
                end
                else if (char_byte == CH_DQ)
                begin
                    state_next = ST_DQ;
                end
                else if (is_terminator(char_byte))
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_END_ARG, CH_NUL);
                    state_next = ST_IDLE;
                end
                else
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, char_byte);
                end
            end
            ST_ARG_ESC:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd2;
                    r0 = mk_result(KIND_END_ARG, CH_NUL);
                    r1 = mk_result(KIND_DONE, CH_NUL);
                    state_next = ST_IDLE;
                end
                else
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, char_byte);
                    state_next = ST_ARG;
                end
            end
            ST_SQ:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_ERROR, CH_NUL);
                    state_next = ST_IDLE;
                end
                else if (char_byte == CH_SQ)
                begin
                    state_next = ST_ARG;
                end
                else if (char_byte == CH_BSL)
                begin
                    state_next = ST_SQ_ESC;
                end
                else
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, char_byte);
                end
            end
            ST_SQ_ESC:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_ERROR, CH_NUL);
                    state_next = ST_IDLE;
                end
                else if ((char_byte == CH_BSL) || (char_byte == CH_SQ))
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, char_byte);
                    state_next = ST_SQ;
                end
                else
                begin
                    // unknown escape: keep the backslash too
                    n = 2'd2;
                    r0 = mk_result(KIND_BYTE, CH_BSL);
                    r1 = mk_result(KIND_BYTE, char_byte);
                    state_next = ST_SQ;
                end
            end
            ST_DQ:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_ERROR, CH_NUL);
                    state_next = ST_IDLE;
                end
                else if (char_byte == CH_DQ)
                begin
                    state_next = ST_ARG;
                end
                else if (char_byte == CH_BSL)
                begin
                    state_next = ST_DQ_ESC;
                end
                else
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, char_byte);
                end
            end
            ST_DQ_ESC:
            begin
                if (char_byte == CH_NUL)
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_ERROR, CH_NUL);
                    state_next = ST_IDLE;
                end
                else
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_BYTE, cook_escape(char_byte));
                    state_next = ST_DQ;
                end
            end
            default:
            begin
                // between arguments: end of string, or drop a blank
                if (char_byte == CH_NUL)
                begin
                    n = 2'd1;
                    r0 = mk_result(KIND_DONE, CH_NUL);
                end
                state_next = ST_IDLE;
            end
        endcase
        r0.last = (n == 2'd1);
        r1.last = 1'b1;
    end

    assign push.count  = n;
    assign push.first  = r0;
    assign push.second = r1;

endmodule

/* sv/satk_result_fifo.sv */
// ----------------------------------------------------------------------------
// satk_result_fifo
// Register queue that takes up to two results a cycle and hands out one.
// ----------------------------------------------------------------------------
module satk_result_fifo
    import satk_pkg::*;
#(
    parameter int DEPTH = SATK_FIFO_DEPTH
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push_en,
    input  satk_push_t                 push,
    input  logic                       pop,
    output logic                       room,
    output logic                       head_valid,
    output satk_result_t               head,
    output logic [$clog2(DEPTH+1)-1:0] fill_count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(DEPTH - 2);

    satk_result_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [PTR_W-1:0] wr_ptr_plus2;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [1:0]       push_n;

    assign push_n = push_en ? push.count : 2'd0;

    always_comb
    begin
        wr_ptr_plus1 = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        wr_ptr_plus2 = (wr_ptr_plus1 == LAST_PTR) ? '0 : wr_ptr_plus1 + PTR_W'(1);
        unique case (push_n)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = wr_ptr_plus2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
        count_next = count_reg + CNT_W'(push_n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push_n == 2'd2)
        begin
            mem_reg[wr_ptr_plus1] <= push.second;
        end
    end

    assign room       = (count_reg <= ROOM_LIMIT);
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign fill_count = count_reg;

endmodule

/* sv/shell_argument_tokenizer_unit.sv */
// ----------------------------------------------------------------------------
// shell_argument_tokenizer_unit
// Byte-stream shell argument splitter with quote and escape handling.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------
//   input   | in_valid / in_stall  | char_in[7:0]
//   output  | out_valid / out_stall| kind[1:0], data[7:0], last
//
// One byte is taken per cycle while in_stall is low. A byte is held in the
// input register until the queue has room, is decoded against the parse
// state, and its zero, one or two results go into a small result queue; the
// first result is visible the cycle after. A byte that yields two results
// needs two pops, so input runs at one byte per cycle only while output drains.
// Input stall rises when the queue cannot take two more results.
// Reset returns the parser to "between arguments" and empties the queue.
//
// ----------------------------------------------------------------------------
`include "shell_argument_tokenizer_unit_assert.svh"

module shell_argument_tokenizer_unit
    import satk_pkg::*;
#(
    parameter int FIFO_DEPTH = SATK_FIFO_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    // input transactions
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_in,
    // result transactions
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic       last
);

    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] ROOM_LIMIT = CNT_W'(FIFO_DEPTH - 2);

    logic             in_valid_reg;
    logic             in_valid_next;
    logic [7:0]       char_reg;
    logic             accept;
    logic             advance;
    logic             room;
    logic             pop;
    satk_push_t       push;
    satk_result_t     head;
    logic [CNT_W-1:0] fill_count;

    // Advance the held byte once the queue has space for its worst case.
    assign advance  = in_valid_reg && room;
    assign in_stall = in_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Hold the byte while stalled; load a new one on each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            char_reg <= char_in;
        end
    end

    satk_parser u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_byte (char_reg),
        .push      (push)
    );

    satk_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_result_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_en    (advance),
        .push       (push),
        .pop        (pop),
        .room       (room),
        .head_valid (out_valid),
        .head       (head),
        .fill_count (fill_count)
    );

    // Drop the head result once the receiver takes it.
    assign pop  = out_valid && !out_stall;
    assign kind = head.kind;
    assign data = head.data;
    assign last = head.last;

    // A byte only moves on when the queue can absorb two results.
    `SATK_ASSERT_IMPL(a_room_on_advance, clk, rst_n, advance, fill_count <= ROOM_LIMIT)
    // Non-byte results carry zero data.
    `SATK_ASSERT_IMPL(a_zero_data, clk, rst_n, out_valid && (kind != KIND_BYTE), data == 8'h00)
    // An accepted input transaction is held in the input register next cycle.
    `SATK_ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, in_valid_reg)

endmodule
